// ===== hdl/uvs_pkg.sv =====
// ============================================================================
// UV sphere package
// Shared widths, polynomial constants, corner codes and helper functions
// used by the UV sphere triangle generator and its channel interfaces.
// ============================================================================
package uvs_pkg;

    localparam int ANGLE_BITS = 12;
    localparam int MAX_LINES  = 256;
    localparam int CFG_W      = 9;
    localparam int IDX_W      = 8;
    localparam int POS_W      = 16;
    localparam int CORNER_W   = 3;
    localparam int MAG_W      = 15;

    // Phase quotient may reach one full turn, so it needs one extra bit.
    localparam int QUO_W = ANGLE_BITS + 1;
    localparam int REM_W = IDX_W + ANGLE_BITS + 2;
    localparam int DEN_W = CFG_W + 1;
    localparam int QBITS = ANGLE_BITS - 2;

    localparam logic [MAG_W-1:0] MAG_ONE = MAG_W'(16384);

    localparam logic [31:0] C1 = 32'd1686629713;
    localparam logic [31:0] C3 = 32'd693598670;
    localparam logic [31:0] C5 = 32'd85569306;
    localparam logic [31:0] C7 = 32'd5026995;
    localparam logic [31:0] C9 = 32'd172272;
    localparam logic [31:0] POLY_C [0:3] = '{C7, C5, C3, C1};

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(21);

    localparam logic REG_LAT_LINES  = 1'b0;
    localparam logic REG_LONG_LINES = 1'b1;

    localparam logic [CORNER_W-1:0] CRN_U_THIS    = 3'd0;
    localparam logic [CORNER_W-1:0] CRN_U_UP      = 3'd1;
    localparam logic [CORNER_W-1:0] CRN_U_UPRIGHT = 3'd2;
    localparam logic [CORNER_W-1:0] CRN_L_THIS    = 3'd3;
    localparam logic [CORNER_W-1:0] CRN_L_UPRIGHT = 3'd4;
    localparam logic [CORNER_W-1:0] CRN_L_RIGHT   = 3'd5;

    typedef struct packed {
        logic [CORNER_W-1:0] corner;
        logic                bad;
        logic                last;
    } t_meta;

    typedef struct packed {
        logic        neg;
        logic [30:0] x;
    } t_sin_arg;

    // Folds a phase into the first quadrant and scales it to Q30.
    function automatic t_sin_arg phase_to_arg(input logic [ANGLE_BITS-1:0] u);
        t_sin_arg              res;
        logic [QBITS:0]        frac;
        frac = {1'b0, u[QBITS-1:0]};
        if (u[QBITS]) begin
            frac = (QBITS+1)'(1 << QBITS) - frac;
        end
        res.neg = u[QBITS+1];
        res.x   = 31'(frac) << (30 - QBITS);
        return res;
    endfunction

    // Product of two Q30 values, truncated back to Q30.
    function automatic logic [31:0] mul_q30(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        return 32'(p >> 30);
    endfunction

endpackage

// ===== hdl/uvs_in_if.sv =====
// ============================================================================
// UV sphere request channel
// Carries one grid cell (latitude row, longitude column) with valid/ready.
// ============================================================================
interface uvs_in_if;
    logic                       valid;
    logic                       ready;
    logic [uvs_pkg::IDX_W-1:0]  lat_index;
    logic [uvs_pkg::IDX_W-1:0]  long_index;

    modport source (output valid, output lat_index, output long_index, input ready);
    modport sink   (input valid, input lat_index, input long_index, output ready);
endinterface

// ===== hdl/uvs_out_if.sv =====
// ============================================================================
// UV sphere result channel
// Carries one triangle corner position with its flags, valid/ready.
// ============================================================================
interface uvs_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [uvs_pkg::POS_W-1:0]  pos_x;
    logic signed [uvs_pkg::POS_W-1:0]  pos_y;
    logic signed [uvs_pkg::POS_W-1:0]  pos_z;
    logic [uvs_pkg::CORNER_W-1:0]      corner;
    logic                              bad_index;
    logic                              last;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output corner, output bad_index, output last, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input corner, input bad_index, input last, output ready);
endinterface

// ===== hdl/uv_sphere_triangle_generator_unit.sv =====
// ============================================================================
// UV sphere triangle generator
// Expands one latitude/longitude cell into up to six triangle corners and
// computes each corner position through a deep fixed-point pipeline.
// ============================================================================
// Path: the corners of a request pass the issue stage, the divider stages,
// the sine stages, the position stage and the output register in order.
// Throughput: one corner per cycle while the single result channel does not
// stall; a request gives 6 corners, 3 on the rows next to a pole, 1 if bad.
// Reset: synchronous, active low; clears all valid bits and the issue stage
// and returns both grid registers to 21 lines.

module uv_sphere_triangle_generator_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [uvs_pkg::CFG_W-1:0]   i_cfg_data,
    uvs_in_if.sink                      i_req,
    uvs_out_if.source                   o_rsp
);

    localparam int DIV_N = uvs_pkg::QUO_W;

    // ------------------------------------------------------------------------
    // Grid registers. The user must change them only while the block is idle;
    // the block does not enforce it. Every pipeline stage reads them directly.
    // ------------------------------------------------------------------------
    logic [uvs_pkg::CFG_W-1:0] r_lat_lines;
    logic [uvs_pkg::CFG_W-1:0] r_long_lines;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_lines  <= uvs_pkg::CFG_RESET;
            r_long_lines <= uvs_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                uvs_pkg::REG_LAT_LINES:  r_lat_lines  <= i_cfg_data;
                uvs_pkg::REG_LONG_LINES: r_long_lines <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together whenever the output register is
    // free or is being drained this cycle.
    logic r_out_vld;
    logic en;
    assign en = !r_out_vld || o_rsp.ready;

    // ------------------------------------------------------------------------
    // Issue stage: holds the accepted request and walks its corners, one per
    // cycle while the pipeline advances. A new request is taken when the stage
    // is idle or in the cycle its predecessor issues its last corner.
    // ------------------------------------------------------------------------
    logic                          r_sq_busy;
    logic [uvs_pkg::IDX_W-1:0]     r_sq_lat;
    logic [uvs_pkg::IDX_W-1:0]     r_sq_lon;
    logic [uvs_pkg::CORNER_W-1:0]  r_sq_corner;
    logic                          r_sq_bad;
    logic                          r_sq_lower;

    logic cfg_ok;
    logic in_bad;
    logic in_upper;
    logic in_lower;
    logic accept;
    logic issue;
    logic sq_done;

    assign cfg_ok = (r_lat_lines >= uvs_pkg::CFG_W'(3))
                 && (r_lat_lines <= uvs_pkg::CFG_W'(uvs_pkg::MAX_LINES))
                 && (r_long_lines >= uvs_pkg::CFG_W'(3))
                 && (r_long_lines <= uvs_pkg::CFG_W'(uvs_pkg::MAX_LINES));

    assign in_bad = !cfg_ok
                 || (i_req.lat_index == '0)
                 || (uvs_pkg::CFG_W'(i_req.lat_index) >= r_lat_lines)
                 || (uvs_pkg::CFG_W'(i_req.long_index) >= r_long_lines);
    assign in_upper = i_req.lat_index > uvs_pkg::IDX_W'(1);
    assign in_lower = uvs_pkg::CFG_W'(i_req.lat_index) < (r_lat_lines - uvs_pkg::CFG_W'(1));

    assign sq_done = r_sq_bad
                  || (r_sq_corner == uvs_pkg::CRN_L_RIGHT)
                  || ((r_sq_corner == uvs_pkg::CRN_U_UPRIGHT) && !r_sq_lower);

    assign i_req.ready = !r_sq_busy || (en && sq_done);
    assign accept      = i_req.valid && i_req.ready;
    assign issue       = en && r_sq_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy   <= 1'b0;
            r_sq_corner <= uvs_pkg::CRN_U_THIS;
        end else if (accept) begin
            r_sq_busy   <= 1'b1;
            r_sq_corner <= (in_bad || in_upper) ? uvs_pkg::CRN_U_THIS : uvs_pkg::CRN_L_THIS;
        end else if (issue && sq_done) begin
            r_sq_busy <= 1'b0;
        end else if (issue) begin
            r_sq_corner <= r_sq_corner + uvs_pkg::CORNER_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sq_lat   <= i_req.lat_index;
            r_sq_lon   <= i_req.long_index;
            r_sq_bad   <= in_bad;
            r_sq_lower <= in_lower;
        end
    end

    // Grid point of the current corner. The column right of the last one
    // lands exactly on a full turn, which wraps to phase zero downstream.
    logic [uvs_pkg::IDX_W-1:0] pt_row;
    logic [uvs_pkg::CFG_W-1:0] pt_col;

    always_comb begin
        unique case (r_sq_corner)
            uvs_pkg::CRN_U_UP: begin
                pt_row = r_sq_lat - uvs_pkg::IDX_W'(1);
                pt_col = uvs_pkg::CFG_W'(r_sq_lon);
            end
            uvs_pkg::CRN_U_UPRIGHT, uvs_pkg::CRN_L_UPRIGHT: begin
                pt_row = r_sq_lat - uvs_pkg::IDX_W'(1);
                pt_col = uvs_pkg::CFG_W'(r_sq_lon) + uvs_pkg::CFG_W'(1);
            end
            uvs_pkg::CRN_L_RIGHT: begin
                pt_row = r_sq_lat;
                pt_col = uvs_pkg::CFG_W'(r_sq_lon) + uvs_pkg::CFG_W'(1);
            end
            default: begin
                pt_row = r_sq_lat;
                pt_col = uvs_pkg::CFG_W'(r_sq_lon);
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Phase dividers: two restoring dividers, one quotient bit per stage.
    // Polar phase = round(row * 2^ANGLE_BITS / (2 * (lat_lines - 1))),
    // azimuth phase = round(col * 2^ANGLE_BITS / long_lines).
    // ------------------------------------------------------------------------
    logic [uvs_pkg::DEN_W-1:0] den_p;
    logic [uvs_pkg::DEN_W-1:0] den_a;
    assign den_p = {r_lat_lines - uvs_pkg::CFG_W'(1), 1'b0};
    assign den_a = uvs_pkg::DEN_W'(r_long_lines);

    logic                         r_dv_vld  [0:DIV_N];
    uvs_pkg::t_meta               r_dv_meta [0:DIV_N];
    logic [uvs_pkg::REM_W-1:0]    r_dp_rem  [0:DIV_N];
    logic [uvs_pkg::REM_W-1:0]    r_da_rem  [0:DIV_N];
    logic [uvs_pkg::QUO_W-1:0]    r_dp_q    [0:DIV_N];
    logic [uvs_pkg::QUO_W-1:0]    r_da_q    [0:DIV_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_N; k++) begin
                r_dv_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_dv_vld[0] <= r_sq_busy;
            for (int k = 1; k <= DIV_N; k++) begin
                r_dv_vld[k] <= r_dv_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [uvs_pkg::REM_W-1:0] dsh_p;
        logic [uvs_pkg::REM_W-1:0] dsh_a;
        if (en) begin
            r_dv_meta[0] <= '{corner: r_sq_corner, bad: r_sq_bad, last: sq_done};
            r_dp_rem[0]  <= (uvs_pkg::REM_W'(pt_row) << uvs_pkg::ANGLE_BITS)
                          + uvs_pkg::REM_W'(r_lat_lines) - uvs_pkg::REM_W'(1);
            r_da_rem[0]  <= (uvs_pkg::REM_W'(pt_col) << uvs_pkg::ANGLE_BITS)
                          + uvs_pkg::REM_W'(r_long_lines >> 1);
            r_dp_q[0]    <= '0;
            r_da_q[0]    <= '0;
            for (int k = 1; k <= DIV_N; k++) begin
                dsh_p = uvs_pkg::REM_W'(den_p) << (DIV_N - k);
                dsh_a = uvs_pkg::REM_W'(den_a) << (DIV_N - k);
                r_dv_meta[k] <= r_dv_meta[k-1];
                if (r_dp_rem[k-1] >= dsh_p) begin
                    r_dp_rem[k] <= r_dp_rem[k-1] - dsh_p;
                    r_dp_q[k]   <= r_dp_q[k-1] | (uvs_pkg::QUO_W'(1) << (DIV_N - k));
                end else begin
                    r_dp_rem[k] <= r_dp_rem[k-1];
                    r_dp_q[k]   <= r_dp_q[k-1];
                end
                if (r_da_rem[k-1] >= dsh_a) begin
                    r_da_rem[k] <= r_da_rem[k-1] - dsh_a;
                    r_da_q[k]   <= r_da_q[k-1] | (uvs_pkg::QUO_W'(1) << (DIV_N - k));
                end else begin
                    r_da_rem[k] <= r_da_rem[k-1];
                    r_da_q[k]   <= r_da_q[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sine pipeline, four lanes: sin p, cos p, sin a, cos a. Each lane folds
    // its phase into a quarter wave and evaluates the odd polynomial with one
    // Q30 multiply per stage.
    // ------------------------------------------------------------------------
    localparam int PL_N = 8;

    logic [uvs_pkg::ANGLE_BITS-1:0] ph_p;
    logic [uvs_pkg::ANGLE_BITS-1:0] ph_a;
    logic [uvs_pkg::ANGLE_BITS-1:0] ph_lane [0:3];
    assign ph_p = r_dp_q[DIV_N][uvs_pkg::ANGLE_BITS-1:0];
    assign ph_a = r_da_q[DIV_N][uvs_pkg::ANGLE_BITS-1:0];
    assign ph_lane[0] = ph_p;
    assign ph_lane[1] = ph_p + uvs_pkg::ANGLE_BITS'(1 << uvs_pkg::QBITS);
    assign ph_lane[2] = ph_a;
    assign ph_lane[3] = ph_a + uvs_pkg::ANGLE_BITS'(1 << uvs_pkg::QBITS);

    logic                       r_pl_vld  [0:PL_N-1];
    uvs_pkg::t_meta             r_pl_meta [0:PL_N-1];
    logic                       r_pl_n    [0:PL_N-1][0:3];
    logic [30:0]                r_pl_x    [0:5][0:3];
    logic [31:0]                r_pl_t    [1:4][0:3];
    logic [31:0]                r_pl_s    [2:5][0:3];
    logic [31:0]                r_pl_r    [0:3];
    logic [uvs_pkg::MAG_W-1:0]  r_pl_m    [0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PL_N; k++) begin
                r_pl_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_pl_vld[0] <= r_dv_vld[DIV_N];
            for (int k = 1; k < PL_N; k++) begin
                r_pl_vld[k] <= r_pl_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        uvs_pkg::t_sin_arg arg;
        logic [32:0]       rnd;
        if (en) begin
            r_pl_meta[0] <= r_dv_meta[DIV_N];
            for (int k = 1; k < PL_N; k++) begin
                r_pl_meta[k] <= r_pl_meta[k-1];
            end
            for (int l = 0; l < 4; l++) begin
                arg = uvs_pkg::phase_to_arg(ph_lane[l]);
                r_pl_n[0][l] <= arg.neg;
                r_pl_x[0][l] <= arg.x;
                for (int k = 1; k < PL_N; k++) begin
                    r_pl_n[k][l] <= r_pl_n[k-1][l];
                end
                for (int k = 1; k <= 5; k++) begin
                    r_pl_x[k][l] <= r_pl_x[k-1][l];
                end
                // x squared
                r_pl_t[1][l] <= uvs_pkg::mul_q30(32'(r_pl_x[0][l]), 32'(r_pl_x[0][l]));
                for (int k = 2; k <= 4; k++) begin
                    r_pl_t[k][l] <= r_pl_t[k-1][l];
                end
                // Horner steps, innermost coefficient first
                r_pl_s[2][l] <= uvs_pkg::C7 - uvs_pkg::mul_q30(uvs_pkg::C9, r_pl_t[1][l]);
                for (int k = 3; k <= 5; k++) begin
                    r_pl_s[k][l] <= uvs_pkg::POLY_C[k-2]
                                  - uvs_pkg::mul_q30(r_pl_s[k-1][l], r_pl_t[k-1][l]);
                end
                r_pl_r[l] <= uvs_pkg::mul_q30(r_pl_s[5][l], 32'(r_pl_x[5][l]));
                // Round Q30 to Q1.14 and clip at one.
                rnd = 33'(r_pl_r[l]) + 33'd32768;
                if ((rnd >> 16) > 33'(uvs_pkg::MAG_ONE)) begin
                    r_pl_m[l] <= uvs_pkg::MAG_ONE;
                end else begin
                    r_pl_m[l] <= uvs_pkg::MAG_W'(rnd >> 16);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Position stage: x = sin p * cos a, z = sin p * sin a, y = cos p. The
    // products are rounded on their magnitude and then take their sign.
    // A bad cell gives all-zero coordinates.
    // ------------------------------------------------------------------------
    logic                                r_ps_vld;
    uvs_pkg::t_meta                      r_ps_meta;
    logic signed [uvs_pkg::POS_W-1:0]    r_ps_x;
    logic signed [uvs_pkg::POS_W-1:0]    r_ps_y;
    logic signed [uvs_pkg::POS_W-1:0]    r_ps_z;

    logic [2*uvs_pkg::MAG_W-1:0]  prod_x;
    logic [2*uvs_pkg::MAG_W-1:0]  prod_z;
    logic [uvs_pkg::POS_W-1:0]    mag_x;
    logic [uvs_pkg::POS_W-1:0]    mag_z;
    logic [uvs_pkg::POS_W-1:0]    mag_y;
    logic                         neg_x;
    logic                         neg_z;

    assign prod_x = (2*uvs_pkg::MAG_W)'(r_pl_m[0]) * (2*uvs_pkg::MAG_W)'(r_pl_m[3]);
    assign prod_z = (2*uvs_pkg::MAG_W)'(r_pl_m[0]) * (2*uvs_pkg::MAG_W)'(r_pl_m[2]);
    assign mag_x  = uvs_pkg::POS_W'((prod_x + (2*uvs_pkg::MAG_W)'(8192)) >> 14);
    assign mag_z  = uvs_pkg::POS_W'((prod_z + (2*uvs_pkg::MAG_W)'(8192)) >> 14);
    assign mag_y  = uvs_pkg::POS_W'(r_pl_m[1]);
    assign neg_x  = r_pl_n[PL_N-1][0] ^ r_pl_n[PL_N-1][3];
    assign neg_z  = r_pl_n[PL_N-1][0] ^ r_pl_n[PL_N-1][2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps_vld <= 1'b0;
        end else if (en) begin
            r_ps_vld <= r_pl_vld[PL_N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ps_meta <= r_pl_meta[PL_N-1];
            if (r_pl_meta[PL_N-1].bad) begin
                r_ps_x <= '0;
                r_ps_y <= '0;
                r_ps_z <= '0;
            end else begin
                r_ps_x <= neg_x ? -$signed(mag_x) : $signed(mag_x);
                r_ps_y <= r_pl_n[PL_N-1][1] ? -$signed(mag_y) : $signed(mag_y);
                r_ps_z <= neg_z ? -$signed(mag_z) : $signed(mag_z);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------------
    uvs_pkg::t_meta                      r_out_meta;
    logic signed [uvs_pkg::POS_W-1:0]    r_out_x;
    logic signed [uvs_pkg::POS_W-1:0]    r_out_y;
    logic signed [uvs_pkg::POS_W-1:0]    r_out_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_ps_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_meta <= r_ps_meta;
            r_out_x    <= r_ps_x;
            r_out_y    <= r_ps_y;
            r_out_z    <= r_ps_z;
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.pos_x     = r_out_x;
    assign o_rsp.pos_y     = r_out_y;
    assign o_rsp.pos_z     = r_out_z;
    assign o_rsp.corner    = r_out_meta.corner;
    assign o_rsp.bad_index = r_out_meta.bad;
    assign o_rsp.last      = r_out_meta.last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_bad_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.bad_index) |->
            (o_rsp.last && o_rsp.corner == uvs_pkg::CRN_U_THIS
             && o_rsp.pos_x == '0 && o_rsp.pos_y == '0 && o_rsp.pos_z == '0))
        else $error("bad cell result is not a single zero corner");

    a_corner_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.corner != 3'd6 && o_rsp.corner != 3'd7))
        else $error("corner number out of range");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_sq_busy)
        else $error("accepted request did not enter the issue stage");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sq_busy && !en) |=> ($stable(r_sq_corner) && r_sq_busy))
        else $error("issue stage moved during a stall");

endmodule
